// ----- sv/depth_to_rgb_pixel_encoder_assert.svh -----
// ----------------------------------------------------------------------------
// Depth-to-RGB encoder assertion macros
// Concurrent checks sampled on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TO_RGB_PIXEL_ENCODER_ASSERT_SVH
`define DEPTH_TO_RGB_PIXEL_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define DTRE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DTRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dtre_pkg.sv -----
// ----------------------------------------------------------------------------
// Depth-to-RGB encoder package
// Widths, encoding constants, register indexes and the pipeline word type.
// ----------------------------------------------------------------------------
package dtre_pkg;

  // Field widths
  localparam int DEPTH_W    = 16;
  localparam int BYTE_W     = 8;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Divider geometry: eight quotient bits, one per cell
  localparam int QUO_W     = 8;
  localparam int DEN_W     = 22;
  localparam int REM_W     = DEN_W + QUO_W;
  localparam int NUM_CELLS = QUO_W;

  // Encoding constants
  localparam int DEPTH_MIN   = 100;
  localparam int DEPTH_MAX   = 2047;
  localparam int GRAY_SCALE  = 25500;
  localparam int GRAY_SPAN   = DEPTH_MAX - DEPTH_MIN;
  localparam int BYTE_MAX    = 255;
  localparam int ADAPT_DEN   = 2 * DEPTH_MAX;
  localparam int PERIOD      = 1024;
  localparam int PERIOD_HALF = PERIOD / 2;
  localparam int RED_OFFSET  = 256;
  localparam int TRI_SHIFT   = 9;
  localparam int PHASE_W     = 10;
  localparam int HPOS_W      = 12;

  // Encoding modes
  localparam logic [MODE_W-1:0] MODE_GRAY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RAW   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADAPT = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LCV  = 2'd1;

  // Word carried down the cell row
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [QUO_W-1:0]  quo;
    logic              q_to_b;
    logic              q_to_gr;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] g;
    logic [BYTE_W-1:0] r;
    logic              frame_end;
  } stage_t;

endpackage

// ----- sv/dtre_if.sv -----
// ----------------------------------------------------------------------------
// Depth-to-RGB encoder channel interfaces
// Valid/ready channels for depth words in and pixel words out.
// ----------------------------------------------------------------------------
interface dtre_in_if;
  logic                         valid;
  logic                         ready;
  logic [dtre_pkg::DEPTH_W-1:0] depth;
  logic                         frame_end_in;

  modport source (output valid, depth, frame_end_in, input ready);
  modport sink (input valid, depth, frame_end_in, output ready);
endinterface

interface dtre_out_if;
  logic                        valid;
  logic                        ready;
  logic [dtre_pkg::BYTE_W-1:0] blue;
  logic [dtre_pkg::BYTE_W-1:0] green;
  logic [dtre_pkg::BYTE_W-1:0] red;
  logic                        frame_end_out;

  modport source (output valid, blue, green, red, frame_end_out, input ready);
  modport sink (input valid, blue, green, red, frame_end_out, output ready);
endinterface

// ----- sv/dtre_prep.sv -----
// ----------------------------------------------------------------------------
// Depth-to-RGB encoder front stage
// Decodes mode and depth range, forms divider operands and the fixed bytes.
// ----------------------------------------------------------------------------
`include "depth_to_rgb_pixel_encoder_assert.svh"

module dtre_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  dtre_in_if.sink                       in_ch,
  input  logic [dtre_pkg::MODE_W-1:0]   mode,
  input  logic [dtre_pkg::DEPTH_W-1:0]  lcv,
  input  logic                          dn_take,
  output logic                          valid_o,
  output dtre_pkg::stage_t              data_o
);

  logic                           valid_r;
  logic                           valid_nxt;
  dtre_pkg::stage_t               data_r;
  dtre_pkg::stage_t               data_nxt;
  logic                           take;
  logic                           in_range;
  logic                           near;
  logic [10:0]                    d11;
  logic [10:0]                    span;
  logic [dtre_pkg::HPOS_W-1:0]    hpos;
  logic [dtre_pkg::HPOS_W-1:0]    roff;
  logic [dtre_pkg::REM_W-1:0]     gray_num;
  logic [dtre_pkg::DEN_W-1:0]     gray_den;
  logic [dtre_pkg::REM_W-1:0]     adapt_num;
  logic [dtre_pkg::BYTE_W-1:0]    tri_g;
  logic [dtre_pkg::BYTE_W-1:0]    tri_r;

  // Fold a phase into a triangle and scale it to a byte
  function automatic logic [dtre_pkg::BYTE_W-1:0] tri_byte(
    input logic [dtre_pkg::PHASE_W-1:0] t
  );
    logic [dtre_pkg::PHASE_W:0]                      fold;
    logic [dtre_pkg::BYTE_W+dtre_pkg::TRI_SHIFT-1:0] prod;
    if (t > dtre_pkg::PHASE_W'(dtre_pkg::PERIOD_HALF)) begin
      fold = (dtre_pkg::PHASE_W+1)'(dtre_pkg::PERIOD) - {1'b0, t};
    end else begin
      fold = {1'b0, t};
    end
    prod = (dtre_pkg::BYTE_W+dtre_pkg::TRI_SHIFT)'(dtre_pkg::BYTE_MAX)
         * (dtre_pkg::BYTE_W+dtre_pkg::TRI_SHIFT)'(fold);
    return prod[dtre_pkg::BYTE_W+dtre_pkg::TRI_SHIFT-1:dtre_pkg::TRI_SHIFT];
  endfunction

  // Range decode
  assign in_range = in_ch.depth <= dtre_pkg::DEPTH_W'(dtre_pkg::DEPTH_MAX);
  assign near     = in_ch.depth < dtre_pkg::DEPTH_W'(dtre_pkg::DEPTH_MIN);
  assign d11      = in_ch.depth[10:0];
  assign span     = 11'(dtre_pkg::DEPTH_MAX) - d11;

  // Grayscale operands: inverse depth scaled to a byte
  assign gray_num = dtre_pkg::REM_W'(dtre_pkg::GRAY_SCALE) * dtre_pkg::REM_W'(span);
  assign gray_den = dtre_pkg::DEN_W'(dtre_pkg::GRAY_SPAN) * dtre_pkg::DEN_W'(d11);

  // Adaptive: half-unit position, red phase mirrored below the offset
  assign hpos      = {d11, 1'b1};
  assign roff      = (hpos >= dtre_pkg::HPOS_W'(dtre_pkg::RED_OFFSET))
                   ? hpos - dtre_pkg::HPOS_W'(dtre_pkg::RED_OFFSET)
                   : dtre_pkg::HPOS_W'(dtre_pkg::RED_OFFSET) - hpos;
  assign adapt_num = dtre_pkg::REM_W'(dtre_pkg::BYTE_MAX) * dtre_pkg::REM_W'(hpos);
  assign tri_g     = tri_byte(hpos[dtre_pkg::PHASE_W-1:0]);
  assign tri_r     = tri_byte(roff[dtre_pkg::PHASE_W-1:0]);

  // Build the word for the divider row
  always_comb begin
    data_nxt           = '0;
    data_nxt.frame_end = in_ch.frame_end_in;
    if (in_ch.depth != lcv) begin
      case (mode)
        dtre_pkg::MODE_GRAY: begin
          if (near) begin
            data_nxt.b = dtre_pkg::BYTE_W'(dtre_pkg::BYTE_MAX);
            data_nxt.g = dtre_pkg::BYTE_W'(dtre_pkg::BYTE_MAX);
            data_nxt.r = dtre_pkg::BYTE_W'(dtre_pkg::BYTE_MAX);
          end else if (in_range) begin
            data_nxt.rem     = gray_num;
            data_nxt.den     = gray_den;
            data_nxt.q_to_b  = 1'b1;
            data_nxt.q_to_gr = 1'b1;
          end
        end
        dtre_pkg::MODE_RAW: begin
          data_nxt.b = {in_ch.depth[15:10], 2'b00};
          data_nxt.g = {in_ch.depth[9:5], 3'b000};
          data_nxt.r = {in_ch.depth[4:0], 3'b000};
        end
        dtre_pkg::MODE_ADAPT: begin
          if (in_range) begin
            data_nxt.rem    = adapt_num;
            data_nxt.den    = dtre_pkg::DEN_W'(dtre_pkg::ADAPT_DEN);
            data_nxt.q_to_b = 1'b1;
            data_nxt.g      = tri_g;
            data_nxt.r      = tri_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Advance when empty or when the next cell takes our word
  assign take        = !valid_r || dn_take;
  assign in_ch.ready = take;
  assign valid_nxt   = take ? in_ch.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_ch.valid) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

  `DTRE_ASSERT_NEXT(a_lowconf_zero,
    in_ch.valid && take && (in_ch.depth == lcv),
    valid_r && !data_r.q_to_b && !data_r.q_to_gr
      && (data_r.b == '0) && (data_r.g == '0) && (data_r.r == '0),
    "low-confidence word not forced to zero")
  `DTRE_ASSERT_SAME(a_den_nonzero, valid_r && data_r.q_to_b, data_r.den != '0,
    "divider word with zero denominator")

endmodule

// ----- sv/dtre_div_cell.sv -----
// ----------------------------------------------------------------------------
// Depth-to-RGB encoder divider cell
// One restoring-division step: resolve one quotient bit, pass the word on.
// ----------------------------------------------------------------------------
`include "depth_to_rgb_pixel_encoder_assert.svh"

module dtre_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  dtre_pkg::stage_t up_data,
  input  logic             dn_take,
  output logic             take,
  output logic             valid_o,
  output dtre_pkg::stage_t data_o
);

  logic                       valid_r;
  logic                       valid_nxt;
  dtre_pkg::stage_t           data_r;
  dtre_pkg::stage_t           data_nxt;
  logic [dtre_pkg::REM_W-1:0] trial;
  logic [dtre_pkg::REM_W-1:0] diff;
  logic                       fits;
  logic [dtre_pkg::REM_W-1:0] rem_bound;

  // Compare against the denominator aligned to the top quotient bit
  assign trial = dtre_pkg::REM_W'({up_data.den, {(dtre_pkg::QUO_W-1){1'b0}}});
  assign fits  = up_data.rem >= trial;
  assign diff  = up_data.rem - trial;

  // Subtract if it fits, shift the remainder, shift in the quotient bit
  always_comb begin
    data_nxt     = up_data;
    data_nxt.rem = fits ? {diff[dtre_pkg::REM_W-2:0], 1'b0}
                        : {up_data.rem[dtre_pkg::REM_W-2:0], 1'b0};
    data_nxt.quo = {up_data.quo[dtre_pkg::QUO_W-2:0], fits};
  end

  // Advance when empty or when downstream takes our word
  assign take      = !valid_r || dn_take;
  assign valid_nxt = take ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

  // Remainder stays below the denominator scaled by the quotient range
  assign rem_bound = {data_r.den, {dtre_pkg::QUO_W{1'b0}}};

  `DTRE_ASSERT_SAME(a_rem_bound, valid_r && data_r.q_to_b, data_r.rem < rem_bound,
    "divider remainder out of range")
  `DTRE_ASSERT_NEXT(a_hold_stall, valid_r && !dn_take, valid_r && $stable(data_r),
    "stalled cell lost or changed its word")

endmodule

// ----- sv/depth_to_rgb_pixel_encoder.sv -----
// Pipeline: a word accepted on in_ch passes the front stage, eight divider
// cells and the output register before it appears on out_ch.
// Throughput: one word per clock while out_ch is ready; a stalled output only
// backs up full stages, so bubbles in the row still let new words in.
// Reset: rst_n is synchronous, active low; clears all valid flags and sets
// mode_r and lcv_r to zero.
// ----------------------------------------------------------------------------
// Depth-to-RGB pixel encoder
// Encodes 16-bit depth words into B,G,R bytes through a row of divider cells.
// ----------------------------------------------------------------------------
module depth_to_rgb_pixel_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  dtre_in_if.sink                          in_ch,
  dtre_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [dtre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dtre_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic [dtre_pkg::MODE_W-1:0]   mode_r;
  logic [dtre_pkg::MODE_W-1:0]   mode_nxt;
  logic [dtre_pkg::DEPTH_W-1:0]  lcv_r;
  logic [dtre_pkg::DEPTH_W-1:0]  lcv_nxt;

  logic [dtre_pkg::NUM_CELLS:0]   chain_valid;
  dtre_pkg::stage_t               chain_data [0:dtre_pkg::NUM_CELLS];
  logic [dtre_pkg::NUM_CELLS+1:1] take_v;

  logic                          out_take;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [dtre_pkg::BYTE_W-1:0]   blue_r;
  logic [dtre_pkg::BYTE_W-1:0]   green_r;
  logic [dtre_pkg::BYTE_W-1:0]   red_r;
  logic                          fend_r;
  logic [dtre_pkg::BYTE_W-1:0]   blue_nxt;
  logic [dtre_pkg::BYTE_W-1:0]   green_nxt;
  logic [dtre_pkg::BYTE_W-1:0]   red_nxt;
  dtre_pkg::stage_t              last;

  // Configuration registers
  always_comb begin
    mode_nxt = mode_r;
    lcv_nxt  = lcv_r;
    if (cfg_we) begin
      case (cfg_index)
        dtre_pkg::CFG_IDX_MODE: mode_nxt = cfg_wdata[dtre_pkg::MODE_W-1:0];
        dtre_pkg::CFG_IDX_LCV:  lcv_nxt  = cfg_wdata[dtre_pkg::DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      lcv_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      lcv_r  <= lcv_nxt;
    end
  end

  // Front stage
  dtre_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .mode    (mode_r),
    .lcv     (lcv_r),
    .dn_take (take_v[1]),
    .valid_o (chain_valid[0]),
    .data_o  (chain_data[0])
  );

  // Row of divider cells, one quotient bit each
  for (genvar k = 0; k < dtre_pkg::NUM_CELLS; k++) begin : g_cell
    dtre_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[k]),
      .up_data  (chain_data[k]),
      .dn_take  (take_v[k+2]),
      .take     (take_v[k+1]),
      .valid_o  (chain_valid[k+1]),
      .data_o   (chain_data[k+1])
    );
  end

  // Output register: pick quotient or fixed byte per colour
  assign last                        = chain_data[dtre_pkg::NUM_CELLS];
  assign out_take                    = !out_valid_r || out_ch.ready;
  assign take_v[dtre_pkg::NUM_CELLS+1] = out_take;
  assign out_valid_nxt = out_take ? chain_valid[dtre_pkg::NUM_CELLS] : out_valid_r;
  assign blue_nxt      = last.q_to_b  ? last.quo : last.b;
  assign green_nxt     = last.q_to_gr ? last.quo : last.g;
  assign red_nxt       = last.q_to_gr ? last.quo : last.r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && chain_valid[dtre_pkg::NUM_CELLS]) begin
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
      fend_r  <= last.frame_end;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.blue          = blue_r;
  assign out_ch.green         = green_r;
  assign out_ch.red           = red_r;
  assign out_ch.frame_end_out = fend_r;

endmodule

// ----- tb/depth_to_rgb_pixel_encoder_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth-to-RGB encoder pixel checker
// Mirrors the encoder's registers from the write port and predicts one pixel
// word per depth word taken in. Each pixel word leaving the encoder is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dtre_pixel_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  dtre_in_if                              in_mon,
  dtre_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [dtre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtre_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              outstanding,
  output int                              mismatches
);
  import dtre_pkg::*;

  // Raw bit packing: six, five and five bits of depth into three bytes
  localparam logic [DEPTH_W-1:0] RAW_B_MASK  = 16'hFC00;
  localparam logic [DEPTH_W-1:0] RAW_G_MASK  = 16'h03E0;
  localparam logic [DEPTH_W-1:0] RAW_R_MASK  = 16'h001F;
  localparam int                 RAW_B_SHIFT = 8;
  localparam int                 RAW_G_SHIFT = 2;
  localparam int                 RAW_R_SHIFT = 3;

  typedef struct packed {
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
    logic              frame_end;
  } pixel_t;

  logic [MODE_W-1:0]  enc_mode;
  logic [DEPTH_W-1:0] lcv_code;
  pixel_t             pixel_q[$];

  // Triangle wave over one period of half-units, scaled to a byte
  function automatic logic [BYTE_W-1:0] tri_level(input int unsigned pos);
    int unsigned phase;
    phase = pos % PERIOD;
    if (phase > PERIOD_HALF) begin
      phase = PERIOD - phase;
    end
    return BYTE_W'((BYTE_MAX * phase) / PERIOD_HALF);
  endfunction

  // Pixel for one depth word under the current mode and low-confidence code
  function automatic pixel_t encode_depth(input logic [DEPTH_W-1:0] d, input logic fe);
    pixel_t      px;
    int unsigned dv;
    int unsigned hpos;
    int unsigned rpos;
    int unsigned lvl;
    px = '0;
    px.frame_end = fe;
    dv = 32'(d);
    if (d != lcv_code) begin
      case (enc_mode)
        MODE_GRAY: begin
          if (dv < DEPTH_MIN) begin
            lvl = BYTE_MAX;
          end else if (dv > DEPTH_MAX) begin
            lvl = 0;
          end else begin
            lvl = (GRAY_SCALE * (DEPTH_MAX - dv)) / (GRAY_SPAN * dv);
          end
          px.blue  = BYTE_W'(lvl);
          px.green = BYTE_W'(lvl);
          px.red   = BYTE_W'(lvl);
        end
        MODE_RAW: begin
          px.blue  = BYTE_W'((d & RAW_B_MASK) >> RAW_B_SHIFT);
          px.green = BYTE_W'((d & RAW_G_MASK) >> RAW_G_SHIFT);
          px.red   = BYTE_W'((d & RAW_R_MASK) << RAW_R_SHIFT);
        end
        MODE_ADAPT: begin
          // far depths stay black; red phase mirrors below its offset
          if (dv <= DEPTH_MAX) begin
            hpos     = 2 * dv + 1;
            rpos     = (hpos >= RED_OFFSET) ? hpos - RED_OFFSET : RED_OFFSET - hpos;
            px.blue  = BYTE_W'((BYTE_MAX * hpos) / ADAPT_DEN);
            px.green = tri_level(hpos);
            px.red   = tri_level(rpos);
          end
        end
        default: ;
      endcase
    end
    return px;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      enc_mode    <= MODE_GRAY;
      lcv_code    <= '0;
      outstanding <= 0;
      mismatches  = 0;
      pixel_q.delete();
    end else begin
      // follow register writes; spare indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_MODE: enc_mode <= cfg_wdata[MODE_W-1:0];
          CFG_IDX_LCV:  lcv_code <= cfg_wdata;
          default: ;
        endcase
      end
      // compare the pixel word leaving the encoder with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel word: blue %0d green %0d red %0d frame_end %0d",
                 out_mon.blue, out_mon.green, out_mon.red, out_mon.frame_end_out);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          if (out_mon.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, out_mon.blue);
            mismatches++;
          end
          if (out_mon.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, out_mon.green);
            mismatches++;
          end
          if (out_mon.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, out_mon.red);
            mismatches++;
          end
          if (out_mon.frame_end_out !== want.frame_end) begin
            $error("frame_end_out: expected %0d, actual %0d",
                   want.frame_end, out_mon.frame_end_out);
            mismatches++;
          end
        end
      end
      // predict the pixel for each depth word taken in
      if (in_mon.valid && in_mon.ready) begin
        pixel_q.insert(pixel_q.size(), encode_depth(in_mon.depth, in_mon.frame_end_in));
      end
      outstanding <= pixel_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth-to-RGB pixel encoder testbench
// Drives depth words through every encoding mode and a range of low-confidence
// settings, first with chosen corner depths, then with random words under
// phases of sender idling and receiver stalls. A checker beside the encoder
// predicts and compares every pixel word.
// ----------------------------------------------------------------------------
module tb;
  import dtre_pkg::*;

  localparam int CLK_HALF_NS     = 10;
  localparam int RESET_CYCLES    = 12;
  localparam int NUM_PHASES      = 16;
  localparam int ITEMS_PER_PHASE = 53;
  localparam int SETTLE_CYCLES   = 16;
  localparam int TIMEOUT_NS      = 4_000_000;
  localparam int IDLE_PCT        = 48;
  localparam int BOTH_IDLE_PCT   = 17;
  localparam int PRESSURE_PHASE  = 6;

  localparam logic [MODE_W-1:0]    MODE_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    outstanding;
  int                    mismatches;
  int                    send_idle_pct;
  int                    recv_stall_pct;

  dtre_in_if  in_ch ();
  dtre_out_if out_ch ();

  depth_to_rgb_pixel_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dtre_pixel_checker pixel_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // Receiver: stall at random with the current odds
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one depth word after a random idle gap; return once it is taken
  task automatic send_word(input logic [DEPTH_W-1:0] d, input logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.depth        <= d;
    in_ch.frame_end_in <= fe;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold the sender until every predicted pixel word has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mode write with random bits above the mode field
  task automatic write_mode(input logic [MODE_W-1:0] mode);
    write_reg(CFG_IDX_MODE, {(CFG_DATA_W - MODE_W)'($urandom), mode});
  endtask

  // Depth mix: low-confidence hits, the near and far knees, and full range
  function automatic logic [DEPTH_W-1:0] rand_depth(input logic [DEPTH_W-1:0] lcv);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return lcv;
    if (pick < 22) return DEPTH_W'($urandom_range(2 * DEPTH_MIN, 0));
    if (pick < 55) return DEPTH_W'($urandom_range(DEPTH_MAX, 0));
    if (pick < 65) return DEPTH_W'($urandom_range(DEPTH_MAX + 24, DEPTH_MAX - 24));
    return DEPTH_W'($urandom_range(16'hFFFF, 0));
  endfunction

  initial begin
    logic [DEPTH_W-1:0] lcv;
    logic [MODE_W-1:0]  mode;
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_IDX_MODE;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.depth        = '0;
    in_ch.frame_end_in = 1'b0;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Grayscale: near saturation, both knees, far depth, low-confidence hit
    write_mode(MODE_GRAY);
    write_reg(CFG_IDX_LCV, 16'd500);
    send_word(16'd0, 1'b0);
    send_word(16'd99, 1'b0);
    send_word(16'd100, 1'b1);
    send_word(16'd2047, 1'b0);
    send_word(16'd2048, 1'b0);
    send_word(16'd500, 1'b1);
    drain();

    // Raw packing at the extremes, low-confidence at all ones
    write_mode(MODE_RAW);
    write_reg(CFG_IDX_LCV, 16'hFFFF);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b1);
    send_word(16'hAAAA, 1'b0);
    send_word(16'h5555, 1'b1);
    drain();

    // Writes to spare indexes must leave both registers alone
    write_reg(CFG_IDX_SPARE_A, 16'h0002);
    write_reg(CFG_IDX_SPARE_B, 16'h1234);
    send_word(16'h1234, 1'b0);
    drain();

    // Adaptive: red phase either side of its offset, far depth, zero code
    write_mode(MODE_ADAPT);
    write_reg(CFG_IDX_LCV, 16'h0000);
    send_word(16'd0, 1'b0);
    send_word(16'd1, 1'b0);
    send_word(16'd127, 1'b1);
    send_word(16'd128, 1'b0);
    send_word(16'd640, 1'b0);
    send_word(16'd2047, 1'b1);
    send_word(16'd2048, 1'b0);
    drain();

    // Unused mode gives black
    write_mode(MODE_UNUSED);
    send_word(16'd1234, 1'b1);
    send_word(16'd40000, 1'b0);
    drain();

    // Random words: every mode under every idling pattern
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = IDLE_PCT;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = IDLE_PCT;
        end
        default: begin
          send_idle_pct  = BOTH_IDLE_PCT;
          recv_stall_pct = BOTH_IDLE_PCT;
        end
      endcase
      case (ph % 4)
        0: mode = MODE_GRAY;
        1: mode = MODE_RAW;
        2: mode = MODE_ADAPT;
        default: mode = MODE_UNUSED;
      endcase
      if (ph == 0) begin
        lcv = '0;
      end else if (ph == 1) begin
        lcv = '1;
      end else if ($urandom_range(1) == 0) begin
        lcv = DEPTH_W'($urandom_range(DEPTH_MAX, 0));
      end else begin
        lcv = DEPTH_W'($urandom_range(16'hFFFF, 0));
      end
      write_mode(mode);
      write_reg(CFG_IDX_LCV, lcv);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold the sender once mid-phase until the pipe is empty
        if (ph == PRESSURE_PHASE && n == ITEMS_PER_PHASE / 2) begin
          drain();
        end
        send_word(rand_depth(lcv), $urandom_range(19) == 0);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("depth_to_rgb_pixel_encoder: match");
    end else begin
      $display("depth_to_rgb_pixel_encoder: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("depth_to_rgb_pixel_encoder: mismatch");
    $finish;
  end

endmodule
